// ===== hw/rtl/bloom_filter_double_hash_assert.svh =====
// assertion macros for the bloom filter block
`ifndef BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BFDH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BFDH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BFDH_ASSERT(lbl, prop, msg)

`define BFDH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/bfdh_pkg.sv =====
// shared types and constants of the bloom filter block
package bfdh_pkg;

    localparam int HASH_W         = 32;
    localparam int MAX_BITS_DEF   = 1024;
    localparam int MAX_HASHES_DEF = 16;
    localparam int NUM_BITS_W     = 11;
    localparam int NUM_HASHES_W   = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;

    localparam logic [HASH_W-1:0] DJB_INIT  = 32'd5381;
    localparam logic [HASH_W-1:0] SDBM_INIT = 32'd0;

    localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RST   = 11'd958;
    localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RST = 5'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 2'd1;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_PROBE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic wr_data;
    } store_ctrl_t;

endpackage

// ===== hw/rtl/bloom_filter_double_hash.sv =====
// top level of the bloom filter with djb2 and sdbm double hashing
// usage:
// key bytes enter on the input channel, one per transaction, with func (0 add,
// 1 query), has_char and last. the item marked last ends the key: both hashes
// are reduced modulo num_bits (saturated to 1..MAX_BITS) by a bit-serial
// divider, then num_hashes probes (at most MAX_HASHES) go to the bit memory
// one per cycle, followed by the drain and finish states (finish alone when
// num_hashes is 0); a query result is loaded into the output register in the
// finish state.
// an add sets the probed bits and gives no result; a query gives one present
// transaction on the output channel. in_stall is high while a key end is at
// work. the output register holds a waiting result while bytes of the next
// key are taken; a query end waits only if the previous result is still
// stalled. after reset a clearing pass writes zeros to all MAX_BITS entries,
// one per cycle, with in_stall high; configuration writes are taken always
// (cfg_ready is tied high) and are used at the next key end.
`include "bloom_filter_double_hash_assert.svh"
module bloom_filter_double_hash
    import bfdh_pkg::*;
#(
    parameter int MAX_BITS   = MAX_BITS_DEF,
    parameter int MAX_HASHES = MAX_HASHES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [7:0]            char_code,
    input  logic                  has_char,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  present,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NW = $clog2(MAX_BITS + 1);
    localparam int IW = $clog2(MAX_BITS);
    localparam int KW = $clog2(MAX_HASHES + 1);

    state_t state_reg;
    state_t state_next;

    logic [NUM_BITS_W-1:0]   num_bits_reg;
    logic [NUM_HASHES_W-1:0] num_hashes_reg;
    logic                    func_reg;
    logic [NW-1:0]           n_reg;
    logic [KW-1:0]           k_reg;
    logic [NW-1:0]           addr_reg;
    logic [NW-1:0]           addr_next;
    logic [NW-1:0]           step_reg;
    logic [KW-1:0]           probe_cnt_reg;
    logic [IW-1:0]           clr_cnt_reg;
    logic                    all_set_reg;
    logic                    rd_valid_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    present_reg;

    logic [NW-1:0]     n_eff;
    logic [KW-1:0]     k_eff;
    logic              in_accept;
    logic              key_end;
    logic [HASH_W-1:0] djb_val;
    logic [HASH_W-1:0] sdbm_val;
    logic [NW-1:0]     rem_a;
    logic [NW-1:0]     rem_b;
    logic              div_done;
    store_ctrl_t       store_ctrl;
    logic [IW-1:0]     store_addr;
    logic              rd_data;
    logic [NW:0]       addr_sum;
    logic [NW:0]       addr_wrap;
    logic              out_load;

    assign in_accept = in_valid && !in_stall;
    assign key_end   = in_accept && last;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign present   = present_reg;

    // saturated register values
    always_comb
    begin
        if (num_bits_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(num_bits_reg) > MAX_BITS)
        begin
            n_eff = NW'(MAX_BITS);
        end
        else
        begin
            n_eff = NW'(num_bits_reg);
        end
        if (32'(num_hashes_reg) > MAX_HASHES)
        begin
            k_eff = KW'(MAX_HASHES);
        end
        else
        begin
            k_eff = KW'(num_hashes_reg);
        end
    end

    bfdh_hash u_hash
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (in_accept && has_char),
        .clr       (key_end),
        .char_code (char_code),
        .djb_val   (djb_val),
        .sdbm_val  (sdbm_val)
    );

    bfdh_divider #(.NW(NW)) u_divider
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (key_end),
        .dividend_a (djb_val),
        .dividend_b (sdbm_val),
        .divisor    (n_reg),
        .rem_a      (rem_a),
        .rem_b      (rem_b),
        .done       (div_done)
    );

    bfdh_store #(.MAX_BITS(MAX_BITS)) u_store
    (
        .clk     (clk),
        .ctrl    (store_ctrl),
        .addr    (store_addr),
        .rd_data (rd_data)
    );

    // next probe index, one compare and subtract
    assign addr_sum  = {1'b0, addr_reg} + {1'b0, step_reg};
    assign addr_wrap = addr_sum - {1'b0, n_reg};
    assign addr_next = (addr_sum >= {1'b0, n_reg}) ? addr_wrap[NW-1:0] : addr_sum[NW-1:0];

    assign out_load = (state_reg == ST_FINISH) && (func_reg == FUNC_QUERY)
                      && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IW'(MAX_BITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (key_end)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = (k_reg == '0) ? ST_FINISH : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (probe_cnt_reg == k_reg - KW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (func_reg == FUNC_ADD || !out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_stall           = 1'b1;
        store_ctrl.wr_en   = 1'b0;
        store_ctrl.rd_en   = 1'b0;
        store_ctrl.wr_data = 1'b1;
        store_addr         = addr_reg[IW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                store_ctrl.wr_en   = 1'b1;
                store_ctrl.wr_data = 1'b0;
                store_addr         = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_PROBE:
            begin
                store_ctrl.wr_en = (func_reg == FUNC_ADD);
                store_ctrl.rd_en = (func_reg == FUNC_QUERY);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            num_bits_reg   <= NUM_BITS_RST;
            num_hashes_reg <= NUM_HASHES_RST;
            clr_cnt_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= store_ctrl.rd_en;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NUM_BITS:   num_bits_reg   <= cfg_data[NUM_BITS_W-1:0];
                    CFG_NUM_HASHES: num_hashes_reg <= cfg_data[NUM_HASHES_W-1:0];
                    default:        num_bits_reg   <= num_bits_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_end)
        begin
            func_reg <= func;
            n_reg    <= n_eff;
            k_reg    <= k_eff;
        end
        if (div_done)
        begin
            addr_reg      <= rem_a;
            step_reg      <= rem_b;
            probe_cnt_reg <= '0;
            all_set_reg   <= 1'b1;
        end
        else
        begin
            if (state_reg == ST_PROBE)
            begin
                addr_reg      <= addr_next;
                probe_cnt_reg <= probe_cnt_reg + KW'(1);
            end
            if (rd_valid_reg && !rd_data)
            begin
                all_set_reg <= 1'b0;
            end
        end
        if (out_load)
        begin
            present_reg <= all_set_reg;
        end
    end

    `BFDH_ASSERT(a_result_from_finish, $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH), "result loaded outside finish")
    `BFDH_ASSERT(a_probe_in_range, (state_reg == ST_PROBE) |-> (addr_reg < n_reg), "probe index not below filter size")
    `BFDH_ASSERT_NEXT(a_key_end_stalls, in_valid && !in_stall && last, in_stall, "input taken during key end")
    `BFDH_ASSERT(a_query_no_write, (state_reg == ST_PROBE && func_reg == FUNC_QUERY) |-> !store_ctrl.wr_en, "memory written during query")
    `BFDH_ASSERT(a_div_done_in_divide, div_done |-> (state_reg == ST_DIVIDE), "divider finished outside divide")

endmodule

// ===== hw/rtl/bfdh_hash.sv =====
// running djb2 and sdbm hashes over the key bytes
module bfdh_hash
    import bfdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              upd,
    input  logic              clr,
    input  logic [7:0]        char_code,
    output logic [HASH_W-1:0] djb_val,
    output logic [HASH_W-1:0] sdbm_val
);

    logic [HASH_W-1:0] djb_reg;
    logic [HASH_W-1:0] sdbm_reg;
    logic [HASH_W-1:0] djb_next;
    logic [HASH_W-1:0] sdbm_next;
    logic [HASH_W-1:0] c_ext;
    logic [HASH_W-1:0] djb_step;
    logic [HASH_W-1:0] sdbm_step;

    assign c_ext     = {{(HASH_W-8){char_code[7]}}, char_code};
    assign djb_step  = (djb_reg << 5) + djb_reg + c_ext;
    assign sdbm_step = c_ext + (sdbm_reg << 6) + (sdbm_reg << 16) - sdbm_reg;

    // value including the byte of the current transaction
    assign djb_val  = upd ? djb_step : djb_reg;
    assign sdbm_val = upd ? sdbm_step : sdbm_reg;

    always_comb
    begin
        djb_next  = djb_reg;
        sdbm_next = sdbm_reg;
        if (clr)
        begin
            djb_next  = DJB_INIT;
            sdbm_next = SDBM_INIT;
        end
        else if (upd)
        begin
            djb_next  = djb_step;
            sdbm_next = sdbm_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            djb_reg  <= DJB_INIT;
            sdbm_reg <= SDBM_INIT;
        end
        else
        begin
            djb_reg  <= djb_next;
            sdbm_reg <= sdbm_next;
        end
    end

endmodule

// ===== hw/rtl/bfdh_divider.sv =====
// bit-serial remainder of both hashes by the filter size
module bfdh_divider
    import bfdh_pkg::*;
#(
    parameter int NW = 11
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend_a,
    input  logic [HASH_W-1:0] dividend_b,
    input  logic [NW-1:0]     divisor,
    output logic [NW-1:0]     rem_a,
    output logic [NW-1:0]     rem_b,
    output logic              done
);

    localparam int CW = $clog2(HASH_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [HASH_W-1:0] qa_reg;
    logic [HASH_W-1:0] qb_reg;
    logic [NW-1:0]     ra_reg;
    logic [NW-1:0]     rb_reg;
    logic [NW-1:0]     ra_next;
    logic [NW-1:0]     rb_next;
    logic [NW:0]       ta;
    logic [NW:0]       tb;
    logic [NW:0]       da;
    logic [NW:0]       db;
    logic [NW:0]       dv;

    assign dv = {1'b0, divisor};
    assign ta = {ra_reg, qa_reg[HASH_W-1]};
    assign tb = {rb_reg, qb_reg[HASH_W-1]};
    assign da = ta - dv;
    assign db = tb - dv;
    assign ra_next = (ta >= dv) ? da[NW-1:0] : ta[NW-1:0];
    assign rb_next = (tb >= dv) ? db[NW-1:0] : tb[NW-1:0];

    assign rem_a = ra_reg;
    assign rem_b = rb_reg;
    assign done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(HASH_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qa_reg <= dividend_a;
            qb_reg <= dividend_b;
            ra_reg <= '0;
            rb_reg <= '0;
        end
        else if (busy_reg)
        begin
            qa_reg <= qa_reg << 1;
            qb_reg <= qb_reg << 1;
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

endmodule

// ===== hw/rtl/bfdh_store.sv =====
// filter bit memory, one write or read port, registered read
module bfdh_store
    import bfdh_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
)
(
    input  logic                        clk,
    input  store_ctrl_t                 ctrl,
    input  logic [$clog2(MAX_BITS)-1:0] addr,
    output logic                        rd_data
);

    logic mem [MAX_BITS];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule
